### rtl/channel_map_write_snooper_assert.svh
// assertion macros for the channel map write snooper
// expects signals clk and rst in the scope where a macro is used
`ifndef CHANNEL_MAP_WRITE_SNOOPER_ASSERT_SVH
`define CHANNEL_MAP_WRITE_SNOOPER_ASSERT_SVH

// same-cycle implication
`define CMWS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmws same-cycle check failed");

// next-cycle implication
`define CMWS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmws next-cycle check failed");

`endif

### rtl/cmws_pkg.sv
// shared constants, command and register codes and types of the channel map write snooper
// no dependencies
package cmws_pkg;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int CHAN_W     = 6;
  localparam int PITCH_W    = 16;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int LOGICAL_CHANNELS_DEF  = 32;
  localparam int PHYSICAL_CHANNELS_DEF = 24;

  localparam logic [CMD_W-1:0] CMD_STORE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CALL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] REG_CALL_ADDR = 2'd0;
  localparam logic [1:0] REG_BASE_OFF  = 2'd1;
  localparam logic [1:0] REG_PITCH     = 2'd2;

  localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd4;

  // all ones reads as -1 on the signed channel fields
  localparam logic [CHAN_W-1:0] UNMAPPED = 6'h3f;

  typedef struct packed {
    logic fwd_rd;
    logic fwd_wr;
    logic rev_rd;
    logic rev_wr;
  } mem_req_t;

  typedef struct packed {
    logic done;
    logic exact;
  } div_stat_t;

endpackage

### rtl/cmws_ifs.sv
// request and response channel interfaces of the channel map write snooper
// depends on cmws_pkg
interface cmws_req_if;
  import cmws_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] value;
  logic [CHAN_W-1:0] phys_query;
  logic [CHAN_W-1:0] log_query;

  modport source (output valid, cmd, address, value, phys_query, log_query, input ready);
  modport sink   (input valid, cmd, address, value, phys_query, log_query, output ready);
endinterface

interface cmws_rsp_if;
  import cmws_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     map_changed;
  logic signed [CHAN_W-1:0] logical_of_phys;
  logic signed [CHAN_W-1:0] physical_of_log;

  modport source (output valid, map_changed, logical_of_phys, physical_of_log, input ready);
  modport sink   (input valid, map_changed, logical_of_phys, physical_of_log, output ready);
endinterface

### rtl/cmws_slot_div.sv
// iterative restoring divider: slot index from region offset and slot pitch, one bit a cycle
// depends on cmws_pkg
module cmws_slot_div #(
  parameter int LOGICAL_CHANNELS = cmws_pkg::LOGICAL_CHANNELS_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 start,
  input  logic [cmws_pkg::PITCH_W+$clog2(LOGICAL_CHANNELS)-1:0] dividend,
  input  logic [cmws_pkg::PITCH_W-1:0]                         divisor,
  output logic [$clog2(LOGICAL_CHANNELS)-1:0]                  quot,
  output cmws_pkg::div_stat_t                                  stat
);
  import cmws_pkg::*;

  localparam int LW = $clog2(LOGICAL_CHANNELS);
  localparam int RW = PITCH_W + LW;
  localparam int IW = (LW > 1) ? $clog2(LW) : 1;

  logic [RW-1:0] rem;
  logic [IW-1:0] idx;
  logic          busy;
  logic          done;
  logic [RW-1:0] dsh;
  logic [RW:0]   trial;

  assign dsh   = RW'(divisor) << idx;
  assign trial = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (idx == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (idx == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
      idx  <= IW'(LW - 1);
    end else if (busy) begin
      if (!trial[RW]) begin
        rem       <= trial[RW-1:0];
        quot[idx] <= 1'b1;
      end
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

  assign stat.done  = done;
  assign stat.exact = (rem == '0);

endmodule

### rtl/cmws_map_mem.sv
// forward and reverse channel map memories, registered reads, valid bits for reset
// depends on cmws_pkg
module cmws_map_mem #(
  parameter int LOGICAL_CHANNELS  = cmws_pkg::LOGICAL_CHANNELS_DEF,
  parameter int PHYSICAL_CHANNELS = cmws_pkg::PHYSICAL_CHANNELS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cmws_pkg::mem_req_t                     req,
  input  logic [$clog2(LOGICAL_CHANNELS)-1:0]    fwd_addr,
  input  logic                                   fwd_wr_mapped,
  input  logic [cmws_pkg::CHAN_W-1:0]            fwd_wr_phys,
  output logic                                   fwd_rd_mapped,
  output logic [cmws_pkg::CHAN_W-1:0]            fwd_rd_phys,
  input  logic [$clog2(PHYSICAL_CHANNELS)-1:0]   rev_addr,
  input  logic [cmws_pkg::CHAN_W-1:0]            rev_wr_slot,
  output logic [cmws_pkg::CHAN_W-1:0]            rev_rd_slot
);
  import cmws_pkg::*;

  logic [CHAN_W:0]   fwd_mem [LOGICAL_CHANNELS];
  logic [CHAN_W-1:0] rev_mem [PHYSICAL_CHANNELS];

  logic [LOGICAL_CHANNELS-1:0]  fwd_vld;
  logic [PHYSICAL_CHANNELS-1:0] rev_vld;

  logic [CHAN_W:0]   fwd_q;
  logic              fwd_q_vld;
  logic [CHAN_W-1:0] rev_q;
  logic              rev_q_vld;

  always_ff @(posedge clk) begin
    if (req.fwd_wr) begin
      fwd_mem[fwd_addr] <= {fwd_wr_mapped, fwd_wr_phys};
    end
    if (req.fwd_rd) begin
      fwd_q     <= fwd_mem[fwd_addr];
      fwd_q_vld <= fwd_vld[fwd_addr];
    end
    if (req.rev_wr) begin
      rev_mem[rev_addr] <= rev_wr_slot;
    end
    if (req.rev_rd) begin
      rev_q     <= rev_mem[rev_addr];
      rev_q_vld <= rev_vld[rev_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= '0;
      rev_vld <= '0;
    end else begin
      if (req.fwd_wr) begin
        fwd_vld[fwd_addr] <= 1'b1;
      end
      if (req.rev_wr) begin
        rev_vld[rev_addr] <= 1'b1;
      end
    end
  end

  assign fwd_rd_mapped = fwd_q_vld && fwd_q[CHAN_W];
  assign fwd_rd_phys   = fwd_q[CHAN_W-1:0];
  assign rev_rd_slot   = rev_q_vld ? rev_q : UNMAPPED;

endmodule

### rtl/channel_map_write_snooper.sv
// channel map write snooper top level: apb registers, item sequencer, output register
// depends on cmws_pkg, cmws_ifs, cmws_slot_div, cmws_map_mem, channel_map_write_snooper_assert.svh
//
// req carries one item per request (cmd, address, value, phys_query, log_query) with
// valid/ready; rsp returns exactly one result per request (map_changed, logical_of_phys,
// physical_of_log). one item is in flight at a time; ready is high while the sequencer idles.
// steps from accept to result valid, each ending when the output register is loaded:
//   call, unused command    : execute
//   lookup                  : execute (one registered read of both map memories), capture
//   store outside region    : execute
//   store off slot boundary : execute, the slot divider
//   store inside region     : execute, the one-bit-a-cycle slot divider, then the
//                             read-modify-write of the map memories
// the next request is taken the cycle after the result is loaded, so items never overlap in
// the sequencer. the output register holds a result while rsp.ready is low;
// the next item is accepted meanwhile and waits at its last step until the register frees.
// reset clears the region base, the registers (slot_pitch to 4) and the valid bits of the
// map memories, so every entry reads unmapped; the block takes items right after reset.
// registers at apb byte addresses 0 call_address, 4 base_offset, 8 slot_pitch; pready
// is tied high and writes are meant only while no item is in flight.
`include "channel_map_write_snooper_assert.svh"

module channel_map_write_snooper #(
  parameter int LOGICAL_CHANNELS  = cmws_pkg::LOGICAL_CHANNELS_DEF,
  parameter int PHYSICAL_CHANNELS = cmws_pkg::PHYSICAL_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cmws_req_if.sink                          req,
  cmws_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cmws_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [cmws_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [cmws_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import cmws_pkg::*;

  localparam int LW = $clog2(LOGICAL_CHANNELS);
  localparam int PW = $clog2(PHYSICAL_CHANNELS);
  localparam int RW = PITCH_W + LW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_WR2  = 3'd4;
  localparam logic [2:0] S_LOOK = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;

  logic [ADDR_W-1:0]  call_address;
  logic [DATA_W-1:0]  base_offset;
  logic [PITCH_W-1:0] slot_pitch;
  logic [ADDR_W-1:0]  region_base;
  logic [RW-1:0]      span;

  logic [CMD_W-1:0]  cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] val_q;
  logic [CHAN_W-1:0] pq_q;
  logic [CHAN_W-1:0] lq_q;

  logic [LW-1:0]     slot_q;
  logic              new_mapped;
  logic [CHAN_W-1:0] new_phys;

  logic                     res_changed;
  logic signed [CHAN_W-1:0] res_lop;
  logic signed [CHAN_W-1:0] res_pol;

  logic                     out_valid;
  logic                     out_changed;
  logic signed [CHAN_W-1:0] out_lop;
  logic signed [CHAN_W-1:0] out_pol;

  logic              apb_wr;
  logic [ADDR_W-1:0] offset;
  logic              in_region;
  logic              pq_ok;
  logic              lq_ok;
  logic              div_start;
  logic [LW-1:0]     div_quot;
  div_stat_t         div_stat;
  mem_req_t          mem_req;
  logic [LW-1:0]     fwd_addr;
  logic [PW-1:0]     rev_addr;
  logic [CHAN_W-1:0] rev_wr_slot;
  logic              fwd_rd_mapped;
  logic [CHAN_W-1:0] fwd_rd_phys;
  logic [CHAN_W-1:0] rev_rd_slot;
  logic              out_free;

  // configuration port
  assign apb_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      call_address <= '0;
      base_offset  <= '0;
      slot_pitch   <= PITCH_RESET;
    end else if (apb_wr) begin
      case (paddr[3:2])
        REG_CALL_ADDR: call_address <= pwdata;
        REG_BASE_OFF:  base_offset  <= pwdata;
        REG_PITCH:     slot_pitch   <= pwdata[PITCH_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CALL_ADDR: prdata = call_address;
      REG_BASE_OFF:  prdata = base_offset;
      REG_PITCH:     prdata = APB_DATA_W'(slot_pitch);
      default:       prdata = '0;
    endcase
  end

  // region length follows the pitch register
  always_ff @(posedge clk) begin
    span <= RW'(slot_pitch) * RW'(LOGICAL_CHANNELS);
  end

  // store classification
  assign offset    = addr_q - region_base;
  assign in_region = (region_base != '0) && (slot_pitch != '0) &&
                     (addr_q >= region_base) && (offset < ADDR_W'(span));
  assign pq_ok     = ({1'b0, pq_q} < (CHAN_W + 1)'(PHYSICAL_CHANNELS));
  assign lq_ok     = ({1'b0, lq_q} < (CHAN_W + 1)'(LOGICAL_CHANNELS));
  assign div_start = (state == S_EXEC) && (cmd_q == CMD_STORE) && in_region;
  assign out_free  = !out_valid || rsp.ready;

  cmws_slot_div #(
    .LOGICAL_CHANNELS (LOGICAL_CHANNELS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset[RW-1:0]),
    .divisor  (slot_pitch),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  // memory access control
  always_comb begin
    mem_req.fwd_rd = ((state == S_EXEC) && (cmd_q == CMD_LOOKUP)) ||
                     ((state == S_DIV) && div_stat.done && div_stat.exact);
    mem_req.rev_rd = (state == S_EXEC) && (cmd_q == CMD_LOOKUP);
    mem_req.fwd_wr = (state == S_FRD);
    mem_req.rev_wr = ((state == S_FRD) && fwd_rd_mapped) || ((state == S_WR2) && new_mapped);

    case (state)
      S_EXEC:  fwd_addr = lq_q[LW-1:0];
      S_DIV:   fwd_addr = div_quot;
      default: fwd_addr = slot_q;
    endcase

    case (state)
      S_EXEC:  rev_addr = pq_q[PW-1:0];
      S_FRD:   rev_addr = fwd_rd_phys[PW-1:0];
      default: rev_addr = new_phys[PW-1:0];
    endcase

    rev_wr_slot = (state == S_FRD) ? UNMAPPED : CHAN_W'(slot_q);
  end

  cmws_map_mem #(
    .LOGICAL_CHANNELS  (LOGICAL_CHANNELS),
    .PHYSICAL_CHANNELS (PHYSICAL_CHANNELS)
  ) u_mem (
    .clk           (clk),
    .rst           (rst),
    .req           (mem_req),
    .fwd_addr      (fwd_addr),
    .fwd_wr_mapped (new_mapped),
    .fwd_wr_phys   (new_phys),
    .fwd_rd_mapped (fwd_rd_mapped),
    .fwd_rd_phys   (fwd_rd_phys),
    .rev_addr      (rev_addr),
    .rev_wr_slot   (rev_wr_slot),
    .rev_rd_slot   (rev_rd_slot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_base <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q)
            CMD_STORE: begin
              state <= in_region ? S_DIV : S_DONE;
            end
            CMD_CALL: begin
              if ((region_base == '0) && (addr_q == call_address)) begin
                region_base <= val_q + base_offset;
              end
              state <= S_DONE;
            end
            CMD_LOOKUP: begin
              state <= S_LOOK;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= div_stat.exact ? S_FRD : S_DONE;
          end
        end
        S_FRD: begin
          state <= S_WR2;
        end
        S_WR2: begin
          state <= S_DONE;
        end
        S_LOOK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req.valid) begin
      cmd_q  <= req.cmd;
      addr_q <= req.address;
      val_q  <= req.value;
      pq_q   <= req.phys_query;
      lq_q   <= req.log_query;
    end
    if (state == S_EXEC) begin
      res_changed <= 1'b0;
      res_lop     <= UNMAPPED;
      res_pol     <= UNMAPPED;
      new_mapped  <= (val_q < DATA_W'(PHYSICAL_CHANNELS));
      new_phys    <= val_q[CHAN_W-1:0];
    end
    if ((state == S_DIV) && div_stat.done) begin
      slot_q <= div_quot;
    end
    if (state == S_WR2) begin
      res_changed <= 1'b1;
    end
    if (state == S_LOOK) begin
      res_lop <= pq_ok ? rev_rd_slot : UNMAPPED;
      res_pol <= (lq_ok && fwd_rd_mapped) ? fwd_rd_phys : UNMAPPED;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_changed <= res_changed;
      out_lop     <= res_lop;
      out_pol     <= res_pol;
    end
  end

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = out_valid;
  assign rsp.map_changed     = out_changed;
  assign rsp.logical_of_phys = out_lop;
  assign rsp.physical_of_log = out_pol;

  `CMWS_ASSERT_IMP(a_map_wr_only_store, mem_req.fwd_wr || mem_req.rev_wr, (cmd_q == CMD_STORE) && ((state == S_FRD) || (state == S_WR2)))
  `CMWS_ASSERT_IMP(a_div_done_in_div, div_stat.done, state == S_DIV)
  `CMWS_ASSERT_NXT(a_base_captured_once, region_base != '0, $stable(region_base))
  `CMWS_ASSERT_IMP(a_changed_from_store, (state == S_DONE) && res_changed, cmd_q == CMD_STORE)

endmodule
